/* rtl/cjs_pkg.sv */
// Shared types, widths, register codes and elaboration-time table helpers
// for the CTMC jump site simulator. No dependencies.
package cjs_pkg;

	localparam int NUM_STATES = 4;
	localparam int BASE_W = 2;
	localparam int SAMPLE_W = 16;
	localparam int TIME_W = 40;
	localparam int COUNT_W = 16;
	localparam int ROW_W = 64;
	localparam int HOLD_W = 16;
	localparam int NLN_W = 16;
	localparam int LN_ENTRY_W = 12;
	localparam int WAIT_W = NLN_W + HOLD_W;
	localparam int CFG_IDX_W = 3;
	localparam int LOG_TABLE_BITS_DEF = 8;
	localparam int LN2_Q12 = 2839;

	typedef logic [BASE_W-1:0] base_t;

	localparam base_t BASE_G = 2'd2;
	localparam logic [TIME_W-1:0] TIME_LIMIT_RST = 40'd1048576;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_0,
		CFG_ROW_1,
		CFG_ROW_2,
		CFG_ROW_3,
		CFG_TIME_LIMIT,
		CFG_START_BASE
	} cfg_idx_t;

	// Per-row outcome of one jump, computed ahead for every possible current base.
	typedef struct packed {
		logic [WAIT_W-1:0] wait_time;
		base_t             next_base;
	} row_res_t;

	// Restoring long division, used only while building constant tables.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			if (r >= den) begin
				r = r - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// round(ln(1 + m / 2^bits) * 4096) via 2*atanh(x/(2+x)) in Q30.
	function automatic logic [LN_ENTRY_W-1:0] ln_entry(input int unsigned m,
			input int unsigned bits);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] term;
		logic [63:0] sum;
		x = (64'(m) << 30) >> bits;
		y = udiv64(x << 30, (64'd1 << 31) + x);
		y2 = (y * y) >> 30;
		term = y;
		sum = '0;
		for (int n = 1; n < 40; n += 2) begin
			sum = sum + udiv64(term, 64'(n));
			term = (term * y2) >> 30;
		end
		sum = sum << 1;
		return LN_ENTRY_W'((sum + (64'd1 << 17)) >> 18);
	endfunction

endpackage

/* rtl/cjs_neg_ln.sv */
// Computes -ln(u / 65536) in Q4.12 from a leading-one search and a mantissa table.
// Depends on cjs_pkg.
module cjs_neg_ln #(
	parameter int LOG_TABLE_BITS = cjs_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic [cjs_pkg::SAMPLE_W-1:0] u,
	output logic [cjs_pkg::NLN_W-1:0]    nln
);

	localparam int TAB_DEPTH = 2 ** LOG_TABLE_BITS;

	logic [cjs_pkg::LN_ENTRY_W-1:0] ln_tab [TAB_DEPTH];

	for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
		localparam logic [cjs_pkg::LN_ENTRY_W-1:0] ENTRY =
			cjs_pkg::ln_entry(g, LOG_TABLE_BITS);
		assign ln_tab[g] = ENTRY;
	end

	logic [cjs_pkg::SAMPLE_W-1:0] uz;
	logic [3:0]                   msb;
	logic [cjs_pkg::SAMPLE_W-1:0] norm;
	logic [LOG_TABLE_BITS-1:0]    mant;
	logic [4:0]                   octaves;
	logic [cjs_pkg::NLN_W-1:0]    whole;

	always_comb begin
		// A zero sample is taken as the smallest nonzero one.
		uz = (u == '0) ? cjs_pkg::SAMPLE_W'(1) : u;
		msb = '0;
		for (int i = 0; i < cjs_pkg::SAMPLE_W; i++) begin
			if (uz[i]) begin
				msb = 4'(i);
			end
		end
		norm = uz << (4'd15 - msb);
		mant = norm[14 -: LOG_TABLE_BITS];
		octaves = 5'd16 - {1'b0, msb};
		whole = cjs_pkg::NLN_W'(32'(octaves) * cjs_pkg::LN2_Q12);
		nln = whole - cjs_pkg::NLN_W'(ln_tab[mant]);
	end

endmodule

/* rtl/cjs_row_eval.sv */
// Evaluates one rate-matrix row for a jump: scaled waiting time and next base.
// Depends on cjs_pkg.
module cjs_row_eval #(
	parameter int ROW_ID = 0
) (
	input  logic [cjs_pkg::NLN_W-1:0]    nln,
	input  logic [cjs_pkg::SAMPLE_W-1:0] uc,
	input  logic [cjs_pkg::ROW_W-1:0]    row,
	output cjs_pkg::row_res_t            res
);

	logic [cjs_pkg::HOLD_W-1:0]     hold;
	logic [15:0]                    t1;
	logic [15:0]                    t2;
	logic [15:0]                    t3;
	logic [31:0]                    pick_prod;
	logic [15:0]                    pick;
	logic [1:0]                     slot;

	always_comb begin
		hold = row[15:0];
		t1 = row[31:16];
		t2 = row[47:32];
		t3 = row[63:48];
		pick_prod = uc * t3;
		pick = pick_prod[31:16];
		priority if (pick < t1) begin
			slot = 2'd0;
		end else if (pick < t2) begin
			slot = 2'd1;
		end else begin
			slot = 2'd2;
		end
		res.wait_time = nln * hold;
		// Off-diagonal bases in code order: skip over this row's own base.
		res.next_base = (slot >= cjs_pkg::base_t'(ROW_ID)) ? slot + 2'd1 : slot;
	end

endmodule

/* rtl/cjs_site_state.sv */
// Site state (base, clock, jump count) and the result register.
// Depends on cjs_pkg.
module cjs_site_state (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  cjs_pkg::row_res_t            res [cjs_pkg::NUM_STATES],
	input  logic [cjs_pkg::TIME_W-1:0]   time_limit,
	input  cjs_pkg::base_t               start_base,
	output cjs_pkg::base_t               new_base,
	output logic [cjs_pkg::TIME_W-1:0]   elapsed_time,
	output logic                         site_done,
	output cjs_pkg::base_t               end_base,
	output logic [cjs_pkg::COUNT_W-1:0]  jump_index
);

	cjs_pkg::base_t              cur_q;
	logic [cjs_pkg::TIME_W-1:0]  clock_q;
	logic [cjs_pkg::COUNT_W-1:0] cnt_q;

	cjs_pkg::row_res_t           sel;
	logic [cjs_pkg::TIME_W:0]    sum;
	logic [cjs_pkg::TIME_W-1:0]  clock_n;
	logic [cjs_pkg::COUNT_W-1:0] cnt_n;
	logic                        done;

	always_comb begin
		sel = res[cur_q];
		sum = {1'b0, clock_q} + (cjs_pkg::TIME_W + 1)'(sel.wait_time);
		clock_n = sum[cjs_pkg::TIME_W] ? '1 : sum[cjs_pkg::TIME_W-1:0];
		cnt_n = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;
		done = (clock_n >= time_limit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= cjs_pkg::BASE_G;
			clock_q <= '0;
			cnt_q <= '0;
		end else if (step) begin
			if (done) begin
				cur_q <= start_base;
				clock_q <= '0;
				cnt_q <= '0;
			end else begin
				cur_q <= sel.next_base;
				clock_q <= clock_n;
				cnt_q <= cnt_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			new_base <= sel.next_base;
			elapsed_time <= clock_n;
			site_done <= done;
			end_base <= done ? cur_q : '0;
			jump_index <= cnt_n;
		end
	end

endmodule

/* rtl/ctmc_jump_site_simulator.sv */
// CTMC jump site simulator: one jump per accepted word, one word per cycle
// while out_ready does not stall it. Pipeline: four register stages (input
// word, -ln, row results, state update). Throughput is set by the clock add
// and base update in the last stage.
// Reset: rows 0, limit 1.0, start base G; site in G at time zero, no jumps.
// Depends on cjs_pkg, cjs_neg_ln, cjs_row_eval and cjs_site_state.
module ctmc_jump_site_simulator #(
	parameter int LOG_TABLE_BITS = cjs_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cjs_pkg::SAMPLE_W-1:0]  uniform_time,
	input  logic [cjs_pkg::SAMPLE_W-1:0]  uniform_choice,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cjs_pkg::BASE_W-1:0]    new_base,
	output logic [cjs_pkg::TIME_W-1:0]    elapsed_time,
	output logic                          site_done,
	output logic [cjs_pkg::BASE_W-1:0]    end_base,
	output logic [cjs_pkg::COUNT_W-1:0]   jump_index,
	input  logic                          cfg_we,
	input  logic [cjs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cjs_pkg::ROW_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [cjs_pkg::ROW_W-1:0]  rows_q [cjs_pkg::NUM_STATES];
	logic [cjs_pkg::TIME_W-1:0] time_limit_q;
	cjs_pkg::base_t             start_base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cjs_pkg::NUM_STATES; i++) begin
				rows_q[i] <= '0;
			end
			time_limit_q <= cjs_pkg::TIME_LIMIT_RST;
			start_base_q <= cjs_pkg::BASE_G;
		end else if (cfg_we) begin
			unique case (cjs_pkg::cfg_idx_t'(cfg_idx))
				cjs_pkg::CFG_ROW_0: rows_q[0] <= cfg_data;
				cjs_pkg::CFG_ROW_1: rows_q[1] <= cfg_data;
				cjs_pkg::CFG_ROW_2: rows_q[2] <= cfg_data;
				cjs_pkg::CFG_ROW_3: rows_q[3] <= cfg_data;
				cjs_pkg::CFG_TIME_LIMIT: time_limit_q <= cfg_data[cjs_pkg::TIME_W-1:0];
				cjs_pkg::CFG_START_BASE: start_base_q <= cfg_data[cjs_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage moves when the one after it is empty or moving.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en1, en2, en3, en4;

	assign en4 = !valid_s4 || out_ready;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_ready = en1;
	assign out_valid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: input word.
	logic [cjs_pkg::SAMPLE_W-1:0] ut_s1, uc_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			ut_s1 <= uniform_time;
			uc_s1 <= uniform_choice;
		end
	end

	// Stage 2: -ln of the time sample, independent of the site state.
	logic [cjs_pkg::NLN_W-1:0]    nln;
	logic [cjs_pkg::NLN_W-1:0]    nln_s2;
	logic [cjs_pkg::SAMPLE_W-1:0] uc_s2;

	cjs_neg_ln #(
		.LOG_TABLE_BITS(LOG_TABLE_BITS)
	) u_neg_ln (
		.u   (ut_s1),
		.nln (nln)
	);

	always_ff @(posedge clk) begin
		if (en2) begin
			nln_s2 <= nln;
			uc_s2 <= uc_s1;
		end
	end

	// Stage 3: every row evaluated ahead, so the last stage only selects a row result and adds its wait.
	cjs_pkg::row_res_t row_res [cjs_pkg::NUM_STATES];
	cjs_pkg::row_res_t res_s3  [cjs_pkg::NUM_STATES];

	for (genvar k = 0; k < cjs_pkg::NUM_STATES; k++) begin : g_row
		cjs_row_eval #(
			.ROW_ID(k)
		) u_row_eval (
			.nln (nln_s2),
			.uc  (uc_s2),
			.row (rows_q[k]),
			.res (row_res[k])
		);

		always_ff @(posedge clk) begin
			if (en3) begin
				res_s3[k] <= row_res[k];
			end
		end
	end

	// Stage 4: state update and result register.
	cjs_site_state u_site_state (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (valid_s3 && en4),
		.res          (res_s3),
		.time_limit   (time_limit_q),
		.start_base   (start_base_q),
		.new_base     (new_base),
		.elapsed_time (elapsed_time),
		.site_done    (site_done),
		.end_base     (end_base),
		.jump_index   (jump_index)
	);

endmodule

/* verif/ctmc_jump_site_simulator_tb.sv */
// Self-checking testbench for ctmc_jump_site_simulator: predicts every jump result
// from the sampled words and register settings and checks them in order.
// Depends on cjs_pkg and the ctmc_jump_site_simulator RTL.
`timescale 1ns / 1ps

module ctmc_jump_site_simulator_tb;

	localparam int LOG_BITS = cjs_pkg::LOG_TABLE_BITS_DEF;
	localparam int PIPE_DEPTH = 4;
	localparam int TIMEOUT_NS = 4_000_000;
	localparam int RX_HOLD_CYCLES = 300;
	localparam logic [cjs_pkg::TIME_W-1:0] TIME_MAX = '1;
	localparam logic [cjs_pkg::COUNT_W-1:0] JUMPS_MAX = '1;
	localparam logic [cjs_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO =
		cjs_pkg::CFG_IDX_W'(cjs_pkg::CFG_START_BASE) + 1'b1;
	localparam logic [cjs_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

	typedef struct {
		cjs_pkg::base_t              next_base;
		logic [cjs_pkg::TIME_W-1:0]  elapsed;
		logic                        done;
		cjs_pkg::base_t              end_b;
		logic [cjs_pkg::COUNT_W-1:0] index;
	} jump_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [cjs_pkg::SAMPLE_W-1:0]   uniform_time = '0;
	logic [cjs_pkg::SAMPLE_W-1:0]   uniform_choice = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [cjs_pkg::BASE_W-1:0]     new_base;
	logic [cjs_pkg::TIME_W-1:0]     elapsed_time;
	logic                           site_done;
	logic [cjs_pkg::BASE_W-1:0]     end_base;
	logic [cjs_pkg::COUNT_W-1:0]    jump_index;
	logic                           cfg_we = 1'b0;
	logic [cjs_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [cjs_pkg::ROW_W-1:0]      cfg_data = '0;

	// Predicted copy of the configuration and of the running site.
	logic [cjs_pkg::ROW_W-1:0]      row_cfg [cjs_pkg::NUM_STATES];
	logic [cjs_pkg::TIME_W-1:0]     limit_cfg;
	cjs_pkg::base_t                 start_cfg;
	cjs_pkg::base_t                 site_base;
	logic [cjs_pkg::TIME_W-1:0]     site_clock;
	logic [cjs_pkg::COUNT_W-1:0]    site_jumps;
	logic [cjs_pkg::LN_ENTRY_W-1:0] ln_q12 [1 << LOG_BITS];

	jump_result_t expected_jumps [$];
	int unsigned  mismatch_count = 0;
	bit           tx_gaps = 1'b0;
	bit           rx_stall = 1'b0;
	int unsigned  rx_hold_requests = 0;
	int unsigned  rx_hold_served = 0;
	int unsigned  rx_hold_left = 0;
	int unsigned  rx_gap_left = 0;

	ctmc_jump_site_simulator DUT (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// round(ln(1 + m / 2^LOG_BITS) * 4096), series 2*atanh(x/(2+x)) in Q30.
	function automatic logic [cjs_pkg::LN_ENTRY_W-1:0] ln1p_q12(input int unsigned m);
		logic [63:0] x;
		logic [63:0] y;
		logic [63:0] y2;
		logic [63:0] term;
		logic [63:0] acc;
		x = (64'(m) << 30) >> LOG_BITS;
		y = (x << 30) / ((64'd1 << 31) + x);
		y2 = (y * y) >> 30;
		term = y;
		acc = '0;
		for (int n = 1; n < 40; n += 2) begin
			acc = acc + term / 64'(n);
			term = (term * y2) >> 30;
		end
		acc = acc << 1;
		return cjs_pkg::LN_ENTRY_W'((acc + (64'd1 << 17)) >> 18);
	endfunction

	// -ln(sample / 65536) in Q4.12; a zero sample counts as one.
	function automatic logic [cjs_pkg::NLN_W-1:0] neg_log_q12(
			input logic [cjs_pkg::SAMPLE_W-1:0] sample);
		logic [cjs_pkg::SAMPLE_W-1:0] u;
		logic [cjs_pkg::SAMPLE_W-1:0] frac;
		int msb;
		logic [LOG_BITS-1:0] idx;
		u = (sample == '0) ? cjs_pkg::SAMPLE_W'(1) : sample;
		msb = 0;
		for (int b = 0; b < cjs_pkg::SAMPLE_W; b++)
			if (u[b])
				msb = b;
		frac = u & ~(cjs_pkg::SAMPLE_W'(1) << msb);
		if (LOG_BITS >= msb)
			idx = LOG_BITS'(32'(frac) << (LOG_BITS - msb));
		else
			idx = LOG_BITS'(32'(frac) >> (msb - LOG_BITS));
		return cjs_pkg::NLN_W'((16 - msb) * cjs_pkg::LN2_Q12 - int'(ln_q12[idx]));
	endfunction

	task automatic predict_jump(input logic [cjs_pkg::SAMPLE_W-1:0] ut,
			input logic [cjs_pkg::SAMPLE_W-1:0] uc);
		logic [cjs_pkg::ROW_W-1:0] row;
		logic [15:0] hold;
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		logic [15:0] pick;
		logic [31:0] wait_q20;
		logic [31:0] product;
		logic [cjs_pkg::TIME_W:0] sum;
		int slot;
		jump_result_t r;
		row = row_cfg[site_base];
		hold = row[15:0];
		t1 = row[31:16];
		t2 = row[47:32];
		t3 = row[63:48];
		wait_q20 = 32'(neg_log_q12(ut)) * 32'(hold);
		product = 32'(uc) * 32'(t3);
		pick = product[31:16];
		slot = (pick < t1) ? 0 : (pick < t2) ? 1 : 2;
		r.next_base = cjs_pkg::base_t'((slot >= int'(site_base)) ? slot + 1 : slot);
		sum = {1'b0, site_clock} + (cjs_pkg::TIME_W + 1)'(wait_q20);
		site_clock = sum[cjs_pkg::TIME_W] ? TIME_MAX : sum[cjs_pkg::TIME_W-1:0];
		if (site_jumps != JUMPS_MAX)
			site_jumps = site_jumps + 1'b1;
		r.done = (site_clock >= limit_cfg);
		r.elapsed = site_clock;
		r.index = site_jumps;
		r.end_b = r.done ? site_base : cjs_pkg::base_t'(0);
		if (r.done) begin
			site_base = start_cfg;
			site_clock = '0;
			site_jumps = '0;
		end else begin
			site_base = r.next_base;
		end
		expected_jumps.push_back(r);
	endtask

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Result checker: every accepted word is compared with the oldest prediction.
	always @(posedge clk) begin
		jump_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_jumps.size() == 0) begin
				$display("%0t: unexpected result word, expected none, actual base %0d time %0h",
					$time, new_base, elapsed_time);
				mismatch_count++;
			end else begin
				want = expected_jumps.pop_front();
				compare_field("new_base", 64'(want.next_base), 64'(new_base));
				compare_field("elapsed_time", 64'(want.elapsed), 64'(elapsed_time));
				compare_field("site_done", 64'(want.done), 64'(site_done));
				compare_field("end_base", 64'(want.end_b), 64'(end_base));
				compare_field("jump_index", 64'(want.index), 64'(jump_index));
			end
		end
	end

	// Receiver: random stall bursts, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (rx_hold_requests != rx_hold_served) begin
			rx_hold_served <= rx_hold_served + 1;
			rx_hold_left <= RX_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_ready <= 1'b0;
		end else if (rx_gap_left != 0) begin
			rx_gap_left <= rx_gap_left - 1;
			out_ready <= 1'b0;
		end else if (rx_stall && $urandom_range(0, 4) == 0) begin
			rx_gap_left <= $urandom_range(1, 12) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	initial begin
		#TIMEOUT_NS;
		$display("ctmc_jump_site_simulator verification failed");
		$finish;
	end

	task automatic send_word(input logic [cjs_pkg::SAMPLE_W-1:0] ut,
			input logic [cjs_pkg::SAMPLE_W-1:0] uc);
		in_valid <= 1'b1;
		uniform_time <= ut;
		uniform_choice <= uc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_jump(ut, uc);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic send_random(input int count);
		logic [cjs_pkg::SAMPLE_W-1:0] ut;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 7))
				0: ut = '0;
				1: ut = cjs_pkg::SAMPLE_W'($urandom_range(1, 255));
				default: ut = cjs_pkg::SAMPLE_W'($urandom);
			endcase
			send_word(ut, cjs_pkg::SAMPLE_W'($urandom));
		end
	endtask

	// Wait until every predicted word has come back and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_jumps.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [cjs_pkg::CFG_IDX_W-1:0] idx,
			input logic [cjs_pkg::ROW_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			cjs_pkg::CFG_ROW_0, cjs_pkg::CFG_ROW_1, cjs_pkg::CFG_ROW_2, cjs_pkg::CFG_ROW_3:
				row_cfg[idx[1:0]] = data;
			cjs_pkg::CFG_TIME_LIMIT: limit_cfg = data[cjs_pkg::TIME_W-1:0];
			cjs_pkg::CFG_START_BASE: start_cfg = data[cjs_pkg::BASE_W-1:0];
			default: ;
		endcase
	endtask

	// Writes every register, with junk above the limit and start-base fields and at the unused indexes.
	// The running site is left where it is.
	task automatic configure(
			input logic [cjs_pkg::NUM_STATES-1:0][cjs_pkg::ROW_W-1:0] rows,
			input logic [cjs_pkg::TIME_W-1:0] limit, input cjs_pkg::base_t start);
		drain();
		cfg_write(cjs_pkg::CFG_ROW_0, rows[0]);
		cfg_write(cjs_pkg::CFG_ROW_1, rows[1]);
		cfg_write(cjs_pkg::CFG_ROW_2, rows[2]);
		cfg_write(cjs_pkg::CFG_ROW_3, rows[3]);
		cfg_write(cjs_pkg::CFG_TIME_LIMIT, {24'($urandom), limit});
		cfg_write(cjs_pkg::CFG_START_BASE, {{$urandom, 30'($urandom)}, start});
		cfg_write(CFG_IDX_SPARE_LO, {$urandom, $urandom});
		cfg_write(CFG_IDX_SPARE_HI, {$urandom, $urandom});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [cjs_pkg::NUM_STATES-1:0][cjs_pkg::ROW_W-1:0] random_rows();
		logic [cjs_pkg::NUM_STATES-1:0][cjs_pkg::ROW_W-1:0] rows;
		logic [15:0] hold;
		logic [15:0] t1;
		logic [15:0] t2;
		logic [15:0] t3;
		for (int s = 0; s < cjs_pkg::NUM_STATES; s++) begin
			hold = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(16, 512));
			if ($urandom_range(0, 4) != 0) begin
				t3 = 16'($urandom_range(3, 65535));
				t1 = 16'($urandom_range(0, t3));
				t2 = 16'($urandom_range(t1, t3));
			end else begin
				t1 = 16'($urandom);
				t2 = 16'($urandom);
				t3 = 16'($urandom);
			end
			rows[s] = {t3, t2, t1, hold};
		end
		return rows;
	endfunction

	function automatic logic [cjs_pkg::TIME_W-1:0] random_limit();
		return cjs_pkg::TIME_W'($urandom_range(1 << 18, 1 << 23));
	endfunction

	// Power-on registers: zero rows leave the clock at zero and send every jump
	// to the third off-diagonal base.
	task automatic test_reset_defaults();
		send_word(16'h0000, 16'h0000);
		send_word(16'hFFFF, 16'hFFFF);
		send_word(16'h8000, 16'h1234);
	endtask

	task automatic test_directed_extremes();
		logic [cjs_pkg::NUM_STATES-1:0][cjs_pkg::ROW_W-1:0] rows;
		rows[0] = {16'hFFFF, 16'h8000, 16'h4000, 16'h0100};
		rows[1] = {16'h0000, 16'h0000, 16'h0000, 16'hFFFF};
		rows[2] = {16'hFFFF, 16'hAAAA, 16'h5555, 16'h0000};
		rows[3] = {16'hFFFF, 16'h4000, 16'hC000, 16'h0080};
		configure(rows, cjs_pkg::TIME_LIMIT_RST, cjs_pkg::base_t'(0));
		send_word(16'h0000, 16'h0000);
		send_word(16'h0001, 16'hFFFF);
		send_word(16'h0002, 16'h4000);
		send_word(16'h00FF, 16'h8000);
		send_word(16'h0100, 16'hBFFF);
		send_word(16'h01FF, 16'h3FFF);
		send_word(16'h7FFF, 16'hC000);
		send_word(16'h8000, 16'h0001);
		send_word(16'hFFFF, 16'h7FFF);
		send_word(16'hAAAA, 16'h5555);
		// A zero limit ends the site on every jump.
		configure(rows, '0, cjs_pkg::base_t'(3));
		send_word(16'h5555, 16'hAAAA);
		send_word(16'hFFFF, 16'h0000);
		send_word(16'h0000, 16'hFFFF);
		send_word(16'h1234, 16'h8000);
	endtask

	task automatic test_random_phases();
		logic [cjs_pkg::TIME_W-1:0] limit;
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: limit = '0;
				1: limit = TIME_MAX;
				default: limit = random_limit();
			endcase
			configure(random_rows(), limit, cjs_pkg::base_t'($urandom_range(0, 3)));
			tx_gaps = (phase != 2) && ($urandom_range(0, 3) != 0);
			rx_stall = (phase != 2) && ($urandom_range(0, 3) != 0);
			send_random(6);
		end
	endtask

	// The receiver holds off while words keep coming, so the block must stall.
	task automatic test_backpressure();
		configure(random_rows(), random_limit(), cjs_pkg::base_t'($urandom_range(0, 3)));
		tx_gaps = 1'b0;
		rx_stall = 1'b0;
		rx_hold_requests++;
		send_random(20);
	endtask

	task automatic test_drain_pause();
		tx_gaps = 1'b1;
		rx_stall = 1'b1;
		send_random(6);
		drain();
		send_random(6);
	endtask

	// Maximum waits against the largest limit drive the clock into saturation;
	// about 370 such jumps are needed to reach it.
	task automatic test_clock_saturation();
		logic [cjs_pkg::NUM_STATES-1:0][cjs_pkg::ROW_W-1:0] rows;
		rows = random_rows();
		for (int s = 0; s < cjs_pkg::NUM_STATES; s++)
			rows[s][15:0] = 16'hFFFF;
		configure(rows, TIME_MAX, cjs_pkg::base_t'($urandom_range(0, 3)));
		tx_gaps = 1'b0;
		rx_stall = 1'b0;
		for (int i = 0; i < 372; i++)
			send_word(16'h0000, cjs_pkg::SAMPLE_W'($urandom));
	endtask

	task automatic test_streaming();
		configure(random_rows(), random_limit(), cjs_pkg::base_t'($urandom_range(0, 3)));
		send_random(12);
	endtask

	initial begin
		for (int m = 0; m < (1 << LOG_BITS); m++)
			ln_q12[LOG_BITS'(m)] = ln1p_q12(m);
		for (int s = 0; s < cjs_pkg::NUM_STATES; s++)
			row_cfg[s] = '0;
		limit_cfg = cjs_pkg::TIME_LIMIT_RST;
		start_cfg = cjs_pkg::BASE_G;
		site_base = cjs_pkg::BASE_G;
		site_clock = '0;
		site_jumps = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_extremes();
		test_random_phases();
		test_backpressure();
		test_drain_pause();
		test_clock_saturation();
		test_streaming();

		drain();
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		if (mismatch_count == 0)
			$display("ctmc_jump_site_simulator verification clean");
		else
			$display("ctmc_jump_site_simulator verification failed");
		$finish;
	end

endmodule
